// ===== rtl/psdm_pkg.sv =====
// ----------------------------------------------------------------------------
// psdm_pkg
// Shared types and constants for the phase stiffness and damping modulator.
// ----------------------------------------------------------------------------
package psdm_pkg;

  // field widths
  localparam int STIFF_W    = 28;
  localparam int DECAY_W    = 16;
  localparam int RATE_W     = 20;
  localparam int MASS_W     = 20;
  localparam int SCALE_W    = 4;
  localparam int PHASE_W    = 3;
  localparam int DT_W       = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 28;

  // shared multiplier: 32 x 20 with a 52-bit product
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 20;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // growth divide by one million: four 12-bit quotient digits, each one
  // estimated by a reciprocal multiply (at most one low) and fixed by one
  // compare and subtract; the quotient always fits in 33 bits
  localparam int DIG_W     = 12;
  localparam int DIV_STEPS = 4;
  localparam int DVD_W     = DIG_W * DIV_STEPS;
  localparam int DIV_REM_W = 20;
  localparam int QUO_W     = 33;
  localparam int RECIP_SH  = 39;
  localparam logic [MUL_B_W-1:0] DIVISOR = 20'd1000000;
  localparam logic [MUL_B_W-1:0] RECIP   = 20'd549755;

  localparam logic [STIFF_W-1:0] SAT_MAX = '1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_STIFF = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REDUCE_FLOOR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SQUEEZE_LIM   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COMP_LIM      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GROWTH_RATE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_APPARENT_MASS = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING_SCALE = 3'd7;

  // register reset values
  localparam logic [STIFF_W-1:0] RST_DEFAULT_STIFF = 28'd39321600;
  localparam logic [STIFF_W-1:0] RST_REDUCE_FLOOR  = 28'd13107200;
  localparam logic [STIFF_W-1:0] RST_SQUEEZE_LIM   = 28'd262144000;
  localparam logic [STIFF_W-1:0] RST_COMP_LIM      = 28'd196608000;
  localparam logic [DECAY_W-1:0] RST_DECAY_FACTOR  = 16'd65208;
  localparam logic [RATE_W-1:0]  RST_GROWTH_RATE   = 20'd68715;
  localparam logic [MASS_W-1:0]  RST_APPARENT_MASS = 20'd98304;
  localparam logic [SCALE_W-1:0] RST_DAMPING_SCALE = 4'd6;

  localparam logic [SCALE_W-1:0] PLAIN_SCALE = 4'd2;

  // task phases
  localparam logic [PHASE_W-1:0] PH_RESET      = 3'd0;
  localparam logic [PHASE_W-1:0] PH_REDUCE     = 3'd1;
  localparam logic [PHASE_W-1:0] PH_SQUEEZE    = 3'd2;
  localparam logic [PHASE_W-1:0] PH_COMPENSATE = 3'd3;
  localparam logic [PHASE_W-1:0] PH_RELEASE    = 3'd4;

  // iterative unit handshake
  typedef struct packed {
    logic start;
  } psdm_iter_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } psdm_iter_rsp_t;

endpackage

// ===== rtl/phase_stiffness_damping_modulator.sv =====
// ----------------------------------------------------------------------------
// phase_stiffness_damping_modulator
// Per-tick stiffness update by task phase with damping from a square root.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall, phase, interval_us): one transfer per
//   control tick. Output channel (out_valid/out_stall, stiffness_out,
//   damping_out): one transfer per input transfer, in order.
//   Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_data),
//   written while the block is idle.
//   One item is worked at a time through a 32x20 multiplier and a bit-serial
//   root unit; in_stall is high until the item's result is loaded.
//   Steps from input transfer to the result load, where the root unit makes
//   R = 16 + ceil(FRAC_BITS/2) root bits (R = 24 at FRAC_BITS = 16):
//     phase 0: root, scale, load; phases 1 and 4: decay, clamp, mass, root,
//     scale, load; phases 2 and 3: growth, four divide digits (estimate, back
//     multiply and fix each), clamp, mass, root, scale, load; phases 5-7: load.
//   The next input transfer is taken the cycle after the result is loaded.
//   The result sits in an output register; while out_stall holds it, a new
//   item is accepted and worked, and waits at the end for the register.
//   Reset (rst, synchronous) restores the register defaults and a stiffness
//   of 600 in Q16, and empties the output register.
// ----------------------------------------------------------------------------
module phase_stiffness_damping_modulator #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               cfg_wr_en,
  input  logic [psdm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [psdm_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [psdm_pkg::PHASE_W-1:0]       phase,
  input  logic [psdm_pkg::DT_W-1:0]          interval_us,
  // output channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [psdm_pkg::STIFF_W-1:0]       stiffness_out,
  output logic [psdm_pkg::STIFF_W-1:0]       damping_out
);
  import psdm_pkg::*;

  localparam int ROOT_W = 16 + (FRAC_BITS + 1) / 2;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int SH_L   = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int SH_R   = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;

  // sequencer states
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECAY     = 4'd1;
  localparam logic [3:0] S_DECAY_CHK = 4'd2;
  localparam logic [3:0] S_GROW1     = 4'd3;
  localparam logic [3:0] S_GROW2     = 4'd4;
  localparam logic [3:0] S_DIV       = 4'd5;
  localparam logic [3:0] S_DIV_EST   = 4'd6;
  localparam logic [3:0] S_MASS      = 4'd7;
  localparam logic [3:0] S_ROOT      = 4'd8;
  localparam logic [3:0] S_ROOT_WAIT = 4'd9;
  localparam logic [3:0] S_SCALE     = 4'd10;
  localparam logic [3:0] S_SAT       = 4'd11;
  localparam logic [3:0] S_DIV_BACK  = 4'd12;
  localparam logic [3:0] S_DIV_FIX   = 4'd13;
  localparam logic [3:0] S_GROW_CHK  = 4'd14;

  // configuration registers
  logic [STIFF_W-1:0] default_stiffness;
  logic [STIFF_W-1:0] reduce_floor;
  logic [STIFF_W-1:0] squeeze_limit;
  logic [STIFF_W-1:0] compensate_limit;
  logic [DECAY_W-1:0] decay_factor;
  logic [RATE_W-1:0]  growth_rate;
  logic [MASS_W-1:0]  apparent_mass;
  logic [SCALE_W-1:0] damping_scale;

  // control and state
  logic [3:0]         state;
  logic [STIFF_W-1:0] stiffness;

  // item payload
  logic [PHASE_W-1:0] phase_r;
  logic [DT_W-1:0]    dt_r;
  logic [SCALE_W-1:0] scale_r;
  logic               plain_r;
  logic               hold_r;
  logic [PROD_W-1:0]  prod;

  // growth divide registers
  logic [DIV_REM_W-1:0] div_rem;
  logic [DVD_W-1:0]     div_dvd;
  logic [DIG_W-1:0]     div_qest;
  logic [2:0]           div_cnt;
  logic [QUO_W-1:0]     quo;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;

  logic               in_xfer;
  logic               out_free;

  logic [STIFF_W-1:0] decayed;
  logic [QUO_W:0]     grown;
  logic [STIFF_W-1:0] grow_limit;
  logic [63:0]        rad_mass;
  logic [63:0]        rad_plain;
  logic [RAD_W-1:0]   radicand;
  logic [STIFF_W-1:0] damp_sat;

  logic [MUL_A_W-1:0] div_t;
  logic [MUL_A_W-1:0] div_try;
  logic               div_fix;
  logic [MUL_A_W-1:0] div_left;
  logic [DIG_W-1:0]   div_digit;

  psdm_iter_req_t     iter_req;
  psdm_iter_rsp_t     iter_rsp;
  logic [ROOT_W-1:0]  iter_result;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_DECAY: begin
        mul_a = MUL_A_W'(stiffness);
        mul_b = MUL_B_W'(decay_factor);
      end
      S_GROW1: begin
        mul_a = MUL_A_W'(stiffness);
        mul_b = growth_rate;
      end
      S_GROW2: begin
        mul_a = prod[47:16];
        mul_b = dt_r;
      end
      S_DIV_EST: begin
        mul_a = div_t;
        mul_b = RECIP;
      end
      S_DIV_BACK: begin
        mul_a = MUL_A_W'(prod[RECIP_SH+DIG_W-1:RECIP_SH]);
        mul_b = DIVISOR;
      end
      S_MASS: begin
        mul_a = MUL_A_W'(stiffness);
        mul_b = apparent_mass;
      end
      // the scaled root stays in the product while the result waits
      S_SCALE, S_SAT: begin
        mul_a = MUL_A_W'(iter_result);
        mul_b = MUL_B_W'(scale_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // values derived from the registered product
  always_comb begin
    decayed    = prod[STIFF_W+15:16];
    grown      = (QUO_W+1)'(stiffness) + (QUO_W+1)'(quo);
    grow_limit = (phase_r == PH_SQUEEZE) ? squeeze_limit : compensate_limit;
    rad_mass   = ({16'b0, prod[47:0]} << SH_L) >> SH_R;
    rad_plain  = 64'(stiffness) << FRAC_BITS;
    radicand   = plain_r ? rad_plain[RAD_W-1:0] : rad_mass[RAD_W-1:0];
    damp_sat   = (|prod[PROD_W-1:STIFF_W]) ? SAT_MAX : prod[STIFF_W-1:0];
  end

  // divide digit: estimate times divisor back out, one correction at most
  always_comb begin
    div_t     = {div_rem, div_dvd[DVD_W-1 -: DIG_W]};
    div_try   = div_t - prod[MUL_A_W-1:0];
    div_fix   = (div_try >= MUL_A_W'(DIVISOR));
    div_left  = div_fix ? (div_try - MUL_A_W'(DIVISOR)) : div_try;
    div_digit = div_qest + DIG_W'(div_fix);
  end

  // iterative unit requests
  assign iter_req.start = (state == S_ROOT);

  psdm_iter #(
    .ROOT_W (ROOT_W)
  ) u_iter (
    .clk      (clk),
    .rst      (rst),
    .req      (iter_req),
    .radicand (radicand),
    .rsp      (iter_rsp),
    .result   (iter_result)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      default_stiffness <= RST_DEFAULT_STIFF;
      reduce_floor      <= RST_REDUCE_FLOOR;
      squeeze_limit     <= RST_SQUEEZE_LIM;
      compensate_limit  <= RST_COMP_LIM;
      decay_factor      <= RST_DECAY_FACTOR;
      growth_rate       <= RST_GROWTH_RATE;
      apparent_mass     <= RST_APPARENT_MASS;
      damping_scale     <= RST_DAMPING_SCALE;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_DEFAULT_STIFF: default_stiffness <= cfg_data;
        REG_REDUCE_FLOOR:  reduce_floor      <= cfg_data;
        REG_SQUEEZE_LIM:   squeeze_limit     <= cfg_data;
        REG_COMP_LIM:      compensate_limit  <= cfg_data;
        REG_DECAY_FACTOR:  decay_factor      <= cfg_data[DECAY_W-1:0];
        REG_GROWTH_RATE:   growth_rate       <= cfg_data[RATE_W-1:0];
        REG_APPARENT_MASS: apparent_mass     <= cfg_data[MASS_W-1:0];
        REG_DAMPING_SCALE: damping_scale     <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer, stiffness state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      stiffness <= RST_DEFAULT_STIFF;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_SAT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            case (phase)
              PH_RESET: begin
                stiffness <= default_stiffness;
                state     <= S_ROOT;
              end
              PH_REDUCE, PH_RELEASE:     state <= S_DECAY;
              PH_SQUEEZE, PH_COMPENSATE: state <= S_GROW1;
              default:                   state <= S_SAT;
            endcase
          end
        end
        S_DECAY:     state <= S_DECAY_CHK;
        S_DECAY_CHK: begin
          if (phase_r == PH_REDUCE) begin
            stiffness <= (decayed < reduce_floor) ? reduce_floor : decayed;
          end else begin
            stiffness <= (decayed < default_stiffness) ? default_stiffness : decayed;
          end
          state <= S_MASS;
        end
        S_GROW1:     state <= S_GROW2;
        S_GROW2:     state <= S_DIV;
        S_DIV:       state <= S_DIV_EST;
        S_DIV_EST:   state <= S_DIV_BACK;
        S_DIV_BACK:  state <= S_DIV_FIX;
        S_DIV_FIX: begin
          if (div_cnt == 3'd1) begin
            state <= S_GROW_CHK;
          end else begin
            state <= S_DIV_EST;
          end
        end
        S_GROW_CHK: begin
          stiffness <= (grown > (QUO_W+1)'(grow_limit)) ? grow_limit
                                                        : grown[STIFF_W-1:0];
          state     <= S_MASS;
        end
        S_MASS:      state <= S_ROOT;
        S_ROOT:      state <= S_ROOT_WAIT;
        S_ROOT_WAIT: begin
          if (iter_rsp.done) begin
            state <= S_SCALE;
          end
        end
        S_SCALE:     state <= S_SAT;
        S_SAT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default:     state <= S_IDLE;
      endcase
    end
  end

  // item payload, product, divide and result registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (in_xfer) begin
      phase_r <= phase;
      dt_r    <= interval_us;
      plain_r <= (phase == PH_RESET);
      hold_r  <= (phase > PH_RELEASE);
      scale_r <= (phase == PH_RESET) ? PLAIN_SCALE : damping_scale;
    end
    // phase 4 at or above the default uses a scale of two
    if (state == S_DECAY_CHK && phase_r == PH_RELEASE && !(decayed < default_stiffness)) begin
      scale_r <= PLAIN_SCALE;
    end
    // top dividend bits are below the divisor, so they start the remainder
    if (state == S_DIV) begin
      div_rem <= DIV_REM_W'(prod[PROD_W-1:DVD_W]);
      div_dvd <= prod[DVD_W-1:0];
      div_cnt <= 3'(DIV_STEPS);
    end
    if (state == S_DIV_BACK) begin
      div_qest <= prod[RECIP_SH+DIG_W-1:RECIP_SH];
    end
    if (state == S_DIV_FIX) begin
      div_rem <= div_left[DIV_REM_W-1:0];
      div_dvd <= div_dvd << DIG_W;
      div_cnt <= div_cnt - 3'd1;
      quo     <= {quo[QUO_W-DIG_W-1:0], div_digit};
    end
    if (state == S_SAT && out_free) begin
      stiffness_out <= stiffness;
      damping_out   <= hold_r ? '0 : damp_sat;
    end
  end

  // checks on the sequencer and the shared unit
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state != S_IDLE))
    else $error("input transfer did not start the sequencer");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    iter_rsp.done |-> (state == S_ROOT_WAIT))
    else $error("iterative unit finished outside the wait state");

  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    iter_req.start |-> !iter_rsp.busy)
    else $error("iterative unit started while busy");

  a_load_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_SAT && out_free) |=> (out_valid && state == S_IDLE))
    else $error("result load did not raise out_valid");

endmodule

// ===== rtl/psdm_iter.sv =====
// ----------------------------------------------------------------------------
// psdm_iter
// Shared bit-serial floor square root, one root bit per cycle through a
// single subtract and compare.
// ----------------------------------------------------------------------------
module psdm_iter #(
  parameter int ROOT_W = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  psdm_pkg::psdm_iter_req_t          req,
  input  logic [2*ROOT_W-1:0]               radicand,
  output psdm_pkg::psdm_iter_rsp_t          rsp,
  output logic [ROOT_W-1:0]                 result
);
  import psdm_pkg::*;

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 3;
  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [REM_W-1:0]  rem;
  logic [RAD_W-1:0]  src;
  logic [ROOT_W-1:0] root;

  logic [REM_W-1:0]  step_a;
  logic [REM_W-1:0]  step_b;
  logic [REM_W:0]    diff;
  logic              step_ge;

  // one trial subtract per cycle
  always_comb begin
    step_a  = {rem[REM_W-3:0], src[RAD_W-1 -: 2]};
    step_b  = REM_W'({root, 2'b01});
    diff    = {1'b0, step_a} - {1'b0, step_b};
    step_ge = ~diff[REM_W];
  end

  // control: busy flag and step count
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(ROOT_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: partial remainder, radicand bits and root bits
  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      root <= '0;
      rem  <= '0;
      src  <= radicand;
    end else if (busy) begin
      rem  <= step_ge ? diff[REM_W-1:0] : step_a;
      root <= {root[ROOT_W-2:0], step_ge};
      src  <= src << 2;
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign result   = root;

endmodule

// ===== tb/sv/phase_stiffness_damping_modulator_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// phase_stiffness_damping_modulator_test
// Drives phase ticks into the modulator and checks every stiffness and
// damping result against an in-bench fixed-point predictor. A directed part
// covers all phases, the clamp and floor paths, zero stiffness and the
// register extremes; random traffic then runs task cycles with random
// settings under three sender/receiver idling profiles.
// ----------------------------------------------------------------------------
module phase_stiffness_damping_modulator_test;
  import psdm_pkg::*;

  localparam int FRAC = 16;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int END_SLACK = 80;
  localparam logic [PHASE_W-1:0] PH_HOLD_FIRST = 3'd5;
  localparam logic [PHASE_W-1:0] PH_HOLD_LAST = 3'd7;
  localparam logic [DT_W-1:0] DT_MAX = '1;

  typedef struct packed {
    logic [STIFF_W-1:0] stiffness;
    logic [STIFF_W-1:0] damping;
  } tick_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [PHASE_W-1:0] phase = '0;
  logic [DT_W-1:0] interval_us = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STIFF_W-1:0] stiffness_out;
  logic [STIFF_W-1:0] damping_out;

  // predictor copy of the registers and the stiffness state
  logic [STIFF_W-1:0] set_default_k = RST_DEFAULT_STIFF;
  logic [STIFF_W-1:0] set_reduce_floor = RST_REDUCE_FLOOR;
  logic [STIFF_W-1:0] set_squeeze_lim = RST_SQUEEZE_LIM;
  logic [STIFF_W-1:0] set_comp_lim = RST_COMP_LIM;
  logic [DECAY_W-1:0] set_decay = RST_DECAY_FACTOR;
  logic [RATE_W-1:0] set_growth = RST_GROWTH_RATE;
  logic [MASS_W-1:0] set_mass = RST_APPARENT_MASS;
  logic [SCALE_W-1:0] set_scale = RST_DAMPING_SCALE;
  logic [STIFF_W-1:0] model_k = RST_DEFAULT_STIFF;

  tick_result_t pending_results[$];
  tick_result_t want;
  int failures = 0;
  int ticks_sent = 0;
  int send_gap_pct = 32;
  int recv_stall_pct = 65;
  int quiet_cycles = 0;

  phase_stiffness_damping_modulator #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .phase(phase),
    .interval_us(interval_us),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .stiffness_out(stiffness_out),
    .damping_out(damping_out)
  );

  always #5 clk = ~clk;

  // exact floor square root, digit by digit
  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] probe;
    rem = v;
    root = '0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  function automatic logic [STIFF_W-1:0] clip28(input logic [63:0] v);
    return (v > 64'(SAT_MAX)) ? SAT_MAX : v[STIFF_W-1:0];
  endfunction

  // scale * sqrt(k * mass), mass kept in Q16
  function automatic logic [STIFF_W-1:0] mass_damping(input logic [63:0] k,
                                                       input logic [SCALE_W-1:0] scale);
    logic [63:0] prod;
    prod = k * 64'(set_mass);
    if (FRAC >= 16) prod = prod << (FRAC - 16);
    else prod = prod >> (16 - FRAC);
    return clip28(64'(scale) * floor_root(prod));
  endfunction

  function automatic logic [63:0] grow_clamped(input logic [63:0] k,
                                               input logic [DT_W-1:0] dt,
                                               input logic [STIFF_W-1:0] ceiling);
    logic [63:0] per_sec;
    logic [63:0] sum;
    per_sec = (k * 64'(set_growth)) >> 16;
    sum = k + (per_sec * 64'(dt)) / 64'd1000000;
    return (sum > 64'(ceiling)) ? 64'(ceiling) : sum;
  endfunction

  // next stiffness and damping for one tick; advances the stiffness state
  function automatic tick_result_t advance_stiffness(input logic [PHASE_W-1:0] ph,
                                                     input logic [DT_W-1:0] dt);
    logic [63:0] k;
    logic [STIFF_W-1:0] d;
    tick_result_t r;
    k = 64'(model_k);
    d = '0;
    case (ph)
      PH_RESET: begin
        k = 64'(set_default_k);
        d = clip28(64'(PLAIN_SCALE) * floor_root(k << FRAC));
      end
      PH_REDUCE: begin
        k = (k * 64'(set_decay)) >> 16;
        if (k < 64'(set_reduce_floor)) k = 64'(set_reduce_floor);
        d = mass_damping(k, set_scale);
      end
      PH_SQUEEZE: begin
        k = grow_clamped(k, dt, set_squeeze_lim);
        d = mass_damping(k, set_scale);
      end
      PH_COMPENSATE: begin
        k = grow_clamped(k, dt, set_comp_lim);
        d = mass_damping(k, set_scale);
      end
      PH_RELEASE: begin
        k = (k * 64'(set_decay)) >> 16;
        if (k < 64'(set_default_k)) begin
          k = 64'(set_default_k);
          d = mass_damping(k, set_scale);
        end else begin
          d = mass_damping(k, PLAIN_SCALE);
        end
      end
      default: d = '0;
    endcase
    model_k = k[STIFF_W-1:0];
    r.stiffness = model_k;
    r.damping = d;
    return r;
  endfunction

  // one input transfer; valid stays high until the next gap or drain
  task automatic send_tick(input logic [PHASE_W-1:0] ph, input logic [DT_W-1:0] dt);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    phase <= ph;
    interval_us <= dt;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(advance_stiffness(ph, dt));
    ticks_sent++;
  endtask

  // wait until every expected result has been taken and the block is quiet
  task automatic settle_pipeline();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_DEFAULT_STIFF: set_default_k = value[STIFF_W-1:0];
      REG_REDUCE_FLOOR:  set_reduce_floor = value[STIFF_W-1:0];
      REG_SQUEEZE_LIM:   set_squeeze_lim = value[STIFF_W-1:0];
      REG_COMP_LIM:      set_comp_lim = value[STIFF_W-1:0];
      REG_DECAY_FACTOR:  set_decay = value[DECAY_W-1:0];
      REG_GROWTH_RATE:   set_growth = value[RATE_W-1:0];
      REG_APPARENT_MASS: set_mass = value[MASS_W-1:0];
      REG_DAMPING_SCALE: set_scale = value[SCALE_W-1:0];
      default: ;
    endcase
  endtask

  // extreme, reset or random value, with junk above narrow fields at times
  function automatic logic [CFG_DATA_W-1:0] pick_setting(input int width,
                                                         input logic [CFG_DATA_W-1:0] rst_val);
    logic [CFG_DATA_W-1:0] field_max;
    logic [CFG_DATA_W-1:0] v;
    field_max = CFG_DATA_W'((64'd1 << width) - 1);
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = field_max;
      2, 3: v = rst_val;
      default: v = CFG_DATA_W'($urandom) & field_max;
    endcase
    if (width < CFG_DATA_W && $urandom_range(0, 1) == 1)
      v = v | (CFG_DATA_W'($urandom) & ~field_max);
    return v;
  endfunction

  task automatic shuffle_settings();
    write_reg(REG_DEFAULT_STIFF, pick_setting(STIFF_W, RST_DEFAULT_STIFF));
    write_reg(REG_REDUCE_FLOOR, pick_setting(STIFF_W, RST_REDUCE_FLOOR));
    write_reg(REG_SQUEEZE_LIM, pick_setting(STIFF_W, RST_SQUEEZE_LIM));
    write_reg(REG_COMP_LIM, pick_setting(STIFF_W, RST_COMP_LIM));
    write_reg(REG_DECAY_FACTOR, pick_setting(DECAY_W, RST_DECAY_FACTOR));
    write_reg(REG_GROWTH_RATE, pick_setting(RATE_W, RST_GROWTH_RATE));
    write_reg(REG_APPARENT_MASS, pick_setting(MASS_W, RST_APPARENT_MASS));
    write_reg(REG_DAMPING_SCALE, pick_setting(SCALE_W, RST_DAMPING_SCALE));
  endtask

  // mostly near the 200 Hz tick, sometimes anywhere in range
  function automatic logic [DT_W-1:0] pick_interval();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return DT_MAX;
      2, 3: return DT_W'($urandom);
      default: return DT_W'($urandom_range(4000, 6000));
    endcase
  endfunction

  // every phase from the reset settings, hold phases included
  task automatic test_phase_walk();
    send_tick(PH_RESET, '0);
    send_tick(PH_REDUCE, DT_MAX);
    send_tick(PH_SQUEEZE, 20'd5000);
    send_tick(PH_SQUEEZE, DT_MAX);
    send_tick(PH_COMPENSATE, DT_MAX);
    send_tick(PH_RELEASE, 20'd5000);
    send_tick(PH_RELEASE, '0);
    send_tick(PH_HOLD_FIRST, DT_MAX);
    send_tick(PH_HOLD_FIRST + 3'd1, '0);
    send_tick(PH_HOLD_LAST, 20'd5000);
  endtask

  // ceilings below the stiffness, zero stiffness, register extremes
  task automatic test_limits_and_zero();
    settle_pipeline();
    write_reg(REG_SQUEEZE_LIM, 28'd1000);
    write_reg(REG_COMP_LIM, '0);
    write_reg(REG_REDUCE_FLOOR, '0);
    send_tick(PH_SQUEEZE, '0);
    send_tick(PH_COMPENSATE, 20'd5000);
    send_tick(PH_SQUEEZE, DT_MAX);
    send_tick(PH_REDUCE, DT_MAX);
    settle_pipeline();
    write_reg(REG_DEFAULT_STIFF, SAT_MAX);
    write_reg(REG_REDUCE_FLOOR, SAT_MAX);
    write_reg(REG_SQUEEZE_LIM, SAT_MAX);
    write_reg(REG_COMP_LIM, SAT_MAX);
    write_reg(REG_DECAY_FACTOR, 28'hFFF_FFFF);
    write_reg(REG_GROWTH_RATE, 28'hFFF_FFFF);
    write_reg(REG_APPARENT_MASS, 28'hFFF_FFFF);
    write_reg(REG_DAMPING_SCALE, 28'hFFF_FFFF);
    send_tick(PH_RESET, DT_MAX);
    send_tick(PH_SQUEEZE, DT_MAX);
    send_tick(PH_COMPENSATE, DT_MAX);
    send_tick(PH_RELEASE, DT_MAX);
    send_tick(PH_REDUCE, '0);
    settle_pipeline();
    write_reg(REG_DEFAULT_STIFF, '0);
    write_reg(REG_DECAY_FACTOR, '0);
    write_reg(REG_DAMPING_SCALE, '0);
    send_tick(PH_RELEASE, 20'd5000);
    send_tick(PH_REDUCE, 20'd5000);
    send_tick(PH_RESET, 20'd5000);
  endtask

  // task cycles with random content, mixed with noise ticks
  task automatic test_random_traffic(input int n_ticks, input int gap_pct, input int stall_pct);
    int start;
    int seg_end;
    int run;
    logic [PHASE_W-1:0] order [4];
    order = '{PH_REDUCE, PH_SQUEEZE, PH_COMPENSATE, PH_RELEASE};
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    start = ticks_sent;
    while (ticks_sent - start < n_ticks) begin
      settle_pipeline();
      shuffle_settings();
      seg_end = ticks_sent + 60;
      while (ticks_sent < seg_end && ticks_sent - start < n_ticks) begin
        if ($urandom_range(0, 3) != 0) begin
          if ($urandom_range(0, 4) != 0) send_tick(PH_RESET, pick_interval());
          for (int i = 0; i < 4; i++) begin
            run = $urandom_range(0, 8);
            repeat (run) send_tick(order[i], pick_interval());
          end
        end else begin
          repeat ($urandom_range(1, 4)) send_tick(PHASE_W'($urandom), DT_W'($urandom));
        end
      end
    end
  endtask

  // result check and receiver stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual stiffness %0d damping %0d",
                 $time, stiffness_out, damping_out);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (stiffness_out !== want.stiffness) begin
          $display("%0t: stiffness_out mismatch, expected %0d, actual %0d",
                   $time, want.stiffness, stiffness_out);
          failures++;
        end
        if (damping_out !== want.damping) begin
          $display("%0t: damping_out mismatch, expected %0d, actual %0d",
                   $time, want.damping, damping_out);
          failures++;
        end
      end
    end
    out_stall <= !rst && ($urandom_range(0, 99) < recv_stall_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_phase_walk();
    test_limits_and_zero();
    test_random_traffic(300, 32, 65);
    test_random_traffic(300, 65, 32);
    test_random_traffic(250, 0, 0);
    settle_pipeline();
    repeat (END_SLACK) @(posedge clk);
    failures += pending_results.size();
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
